FILE: src/itm_pkg.sv
package itm_pkg;

	localparam int WINDOW_DEPTH_DEF = 16;

	localparam int TS_W      = 64;
	localparam int PCT_W     = 7;
	localparam int QUO_STEPS = 7;
	localparam int NUM_W     = TS_W + QUO_STEPS;
	localparam int DSH_W     = TS_W + QUO_STEPS - 1;
	localparam int STEP_W    = $clog2(QUO_STEPS);

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	localparam logic [1:0] EV_ENTER  = 2'd0;
	localparam logic [1:0] EV_EXIT   = 2'd1;
	localparam logic [1:0] EV_REPORT = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_EXIT_ADD,
		S_CHECK,
		S_DIV,
		S_PUSH,
		S_MEAN_LOAD,
		S_MDIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic set_enter;
		logic exit_diff;
		logic exit_add;
		logic first_rep;
		logic rep_diff;
		logic commit;
		logic set_full;
		logic div_load_share;
		logic div_load_mean;
		logic div_step;
		logic push;
		logic clr_q;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] code;
		logic       started;
		logic       e_zero;
		logic       d_ge_e;
		logic       div_last;
		logic       ring_empty;
		logic       out_free;
	} sts_t;

endpackage

FILE: src/itm_ctrl.sv
module itm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          event_valid,
	output logic          event_ready,
	input  itm_pkg::sts_t sts,
	output itm_pkg::cmd_t cmd
);

	itm_pkg::state_t state_q;
	itm_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itm_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			itm_pkg::S_IDLE: begin
				if (event_valid) state_nx = itm_pkg::S_DECODE;
			end
			itm_pkg::S_DECODE: begin
				case (sts.code)
					itm_pkg::EV_ENTER:  state_nx = itm_pkg::S_IDLE;
					itm_pkg::EV_EXIT:   state_nx = itm_pkg::S_EXIT_ADD;
					itm_pkg::EV_REPORT: state_nx = sts.started ? itm_pkg::S_CHECK
					                                           : itm_pkg::S_OUT;
					default:            state_nx = itm_pkg::S_IDLE;
				endcase
			end
			itm_pkg::S_EXIT_ADD: state_nx = itm_pkg::S_IDLE;
			itm_pkg::S_CHECK: begin
				if (sts.e_zero) state_nx = itm_pkg::S_MEAN_LOAD;
				else if (sts.d_ge_e) state_nx = itm_pkg::S_PUSH;
				else state_nx = itm_pkg::S_DIV;
			end
			itm_pkg::S_DIV: begin
				if (sts.div_last) state_nx = itm_pkg::S_PUSH;
			end
			itm_pkg::S_PUSH: state_nx = itm_pkg::S_MEAN_LOAD;
			itm_pkg::S_MEAN_LOAD: begin
				state_nx = sts.ring_empty ? itm_pkg::S_OUT : itm_pkg::S_MDIV;
			end
			itm_pkg::S_MDIV: begin
				if (sts.div_last) state_nx = itm_pkg::S_OUT;
			end
			itm_pkg::S_OUT: begin
				if (sts.out_free) state_nx = itm_pkg::S_IDLE;
			end
			default: state_nx = itm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		event_ready = 1'b0;
		case (state_q)
			itm_pkg::S_IDLE: begin
				event_ready = 1'b1;
				cmd.capture = event_valid;
			end
			itm_pkg::S_DECODE: begin
				case (sts.code)
					itm_pkg::EV_ENTER:  cmd.set_enter = 1'b1;
					itm_pkg::EV_EXIT:   cmd.exit_diff = 1'b1;
					itm_pkg::EV_REPORT: begin
						cmd.first_rep = !sts.started;
						cmd.rep_diff  = sts.started;
					end
					default: cmd = '0;
				endcase
			end
			itm_pkg::S_EXIT_ADD: cmd.exit_add = 1'b1;
			itm_pkg::S_CHECK: begin
				cmd.commit         = !sts.e_zero;
				cmd.set_full       = !sts.e_zero && sts.d_ge_e;
				cmd.div_load_share = !sts.e_zero && !sts.d_ge_e;
			end
			itm_pkg::S_DIV:  cmd.div_step = 1'b1;
			itm_pkg::S_PUSH: cmd.push = 1'b1;
			itm_pkg::S_MEAN_LOAD: begin
				cmd.clr_q         = sts.ring_empty;
				cmd.div_load_mean = !sts.ring_empty;
			end
			itm_pkg::S_MDIV: cmd.div_step = 1'b1;
			itm_pkg::S_OUT:  cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	// a divide pass only ever leaves toward its consumer
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == itm_pkg::S_DIV |=> state_q == itm_pkg::S_DIV || state_q == itm_pkg::S_PUSH)
		else $error("share divide left to wrong state");
	a_mdiv_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == itm_pkg::S_MDIV |=> state_q == itm_pkg::S_MDIV || state_q == itm_pkg::S_OUT)
		else $error("mean divide left to wrong state");

endmodule

FILE: src/itm_dp.sv
module itm_dp #(
	parameter int WINDOW_DEPTH = itm_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 event_code,
	input  logic [itm_pkg::TS_W-1:0]   timestamp,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic [itm_pkg::PCT_W-1:0]  idle_percent,
	input  itm_pkg::cmd_t              cmd,
	output itm_pkg::sts_t              sts
);

	localparam int HW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int SW = $clog2(100 * WINDOW_DEPTH + 1);

	localparam int TS_W  = itm_pkg::TS_W;
	localparam int PCT_W = itm_pkg::PCT_W;
	localparam int NUM_W = itm_pkg::NUM_W;
	localparam int DSH_W = itm_pkg::DSH_W;

	logic                started_q;
	logic [TS_W-1:0]     idle_total_q;
	logic [TS_W-1:0]     enter_time_q;
	logic [TS_W-1:0]     last_report_q;
	logic [TS_W-1:0]     last_idle_q;
	logic [HW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [SW-1:0]       sum_q;
	logic                out_valid_q;

	logic [1:0]          code_q;
	logic [TS_W-1:0]     ts_q;
	logic [TS_W-1:0]     a_q;
	logic [TS_W-1:0]     b_q;
	logic [NUM_W-1:0]    rem_q;
	logic [DSH_W-1:0]    dsh_q;
	logic [PCT_W-1:0]    quo_q;
	logic [itm_pkg::STEP_W-1:0] step_q;
	logic [PCT_W-1:0]    rd_q;
	logic [PCT_W-1:0]    pct_q;

	logic [PCT_W-1:0]    ring_mem [0:WINDOW_DEPTH-1];

	logic                ring_full;
	logic                fits;
	logic [NUM_W-1:0]    rem_sub;
	logic [NUM_W-1:0]    times100;

	assign ring_full = count_q == CW'(WINDOW_DEPTH);
	assign fits      = rem_q >= NUM_W'(dsh_q);
	assign rem_sub   = rem_q - NUM_W'(dsh_q);
	assign times100  = NUM_W'({a_q, 6'b0}) + NUM_W'({a_q, 5'b0}) + NUM_W'({a_q, 2'b0});

	assign sts.code       = code_q;
	assign sts.started    = started_q;
	assign sts.e_zero     = b_q == '0;
	assign sts.d_ge_e     = a_q >= b_q;
	assign sts.div_last   = step_q == '0;
	assign sts.ring_empty = count_q == '0;
	assign sts.out_free   = !out_valid_q || result_ready;

	assign result_valid = out_valid_q;
	assign idle_percent = pct_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q     <= 1'b0;
			idle_total_q  <= '0;
			enter_time_q  <= '0;
			last_report_q <= '0;
			last_idle_q   <= '0;
			head_q        <= '0;
			count_q       <= '0;
			sum_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.set_enter) enter_time_q <= ts_q;
			if (cmd.exit_add) idle_total_q <= idle_total_q + a_q;
			if (cmd.first_rep) started_q <= 1'b1;
			if (cmd.first_rep || cmd.commit) begin
				last_report_q <= ts_q;
				last_idle_q   <= idle_total_q;
			end
			if (cmd.push) begin
				sum_q <= sum_q - (ring_full ? SW'(rd_q) : SW'(0)) + SW'(quo_q);
				if (!ring_full) count_q <= count_q + CW'(1);
				head_q <= (head_q == HW'(WINDOW_DEPTH - 1)) ? '0 : head_q + HW'(1);
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			code_q <= event_code;
			ts_q   <= timestamp;
		end
		if (cmd.exit_diff) a_q <= ts_q - enter_time_q;
		if (cmd.rep_diff) begin
			a_q <= idle_total_q - last_idle_q;
			b_q <= ts_q - last_report_q;
		end
		if (cmd.div_load_share) begin
			rem_q  <= times100;
			dsh_q  <= {b_q, (itm_pkg::QUO_STEPS - 1)'(0)};
			quo_q  <= '0;
			step_q <= itm_pkg::STEP_W'(itm_pkg::QUO_STEPS - 1);
		end else if (cmd.div_load_mean) begin
			rem_q  <= NUM_W'(sum_q);
			dsh_q  <= DSH_W'(count_q) << (itm_pkg::QUO_STEPS - 1);
			quo_q  <= '0;
			step_q <= itm_pkg::STEP_W'(itm_pkg::QUO_STEPS - 1);
		end else if (cmd.div_step) begin
			if (fits) rem_q <= rem_sub;
			quo_q  <= {quo_q[PCT_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
			step_q <= step_q - itm_pkg::STEP_W'(1);
		end else if (cmd.set_full) begin
			quo_q <= itm_pkg::PCT_FULL;
		end else if (cmd.clr_q || cmd.first_rep) begin
			quo_q <= '0;
		end
		if (cmd.out_load) pct_q <= quo_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) ring_mem[head_q] <= quo_q;
		rd_q <= ring_mem[head_q];
	end

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(sum_q) <= 100 * int'(count_q))
		else $error("ring sum exceeds 100 per entry");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> count_q != '0)
		else $error("ring empty after push");

endmodule

FILE: src/idle_time_utilization_monitor_core.sv
// A first report tick goes straight to the output; a zero-elapsed tick runs only the mean divide
// (none when the window is empty), a saturated share skips the share divide, and others run both.
// One transaction at a time: a new one is taken while a result waits,
// and the next report holds in output.
// Report cost is set by the shared 7-step restoring divider (share, then mean).
// arst_n clears totals, timestamps, ring head/count/sum and result_valid; ring storage is not cleared.
module idle_time_utilization_monitor_core #(
	parameter int WINDOW_DEPTH = itm_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       event_valid,
	output logic                       event_ready,
	input  logic [1:0]                 event_code,
	input  logic [itm_pkg::TS_W-1:0]   timestamp,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic [itm_pkg::PCT_W-1:0]  idle_percent
);

	// commands down, status up; nothing else crosses between the two halves
	itm_pkg::cmd_t cmd;
	itm_pkg::sts_t sts;

	// sequence each transaction: decode, divide, push into the ring, average
	itm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	// hold timer state, the ring, the divider and the output register
	itm_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.event_code   (event_code),
		.timestamp    (timestamp),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.idle_percent (idle_percent),
		.cmd          (cmd),
		.sts          (sts)
	);

	// a mean of clamped shares can never pass full scale
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> idle_percent <= itm_pkg::PCT_FULL)
		else $error("idle percentage above 100");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int WINDOW_DEPTH = itm_pkg::WINDOW_DEPTH_DEF;
	localparam logic [1:0] EV_UNUSED = 2'd3;
	// Hold the result side off once, early in the first phase, while input keeps coming.
	localparam int HOLD_AT     = 40;
	localparam int HOLD_CYCLES = 400;
	// Settle well past the longest report at the end.
	localparam int SETTLE_CYCLES = 60;
	localparam int MAX_REPORTS   = 10;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [1:0]  code;
		logic [63:0] stamp;
	} idle_event_t;

	// Clock and reset. Every block input starts at a known value.
	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        event_valid  = 1'b0;
	logic        event_ready;
	logic [1:0]  event_code   = itm_pkg::EV_ENTER;
	logic [63:0] timestamp    = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [6:0]  idle_percent;

	always #10 clk = ~clk;

	idle_time_utilization_monitor_core #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.event_code  (event_code),
		.timestamp   (timestamp),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.idle_percent(idle_percent)
	);

	// Stimulus and scoreboard state.
	idle_event_t pending_events[$];
	logic [6:0]  expected_percents[$];
	idle_mode_t  idle_mode       = IDLE_NONE;
	int          events_accepted = 0;
	int          hold_left       = 0;
	logic        hold_done       = 1'b0;
	int          error_count     = 0;
	logic [63:0] time_cursor     = '0;

	// Predictor state: idle bookkeeping plus the window of recent idle shares.
	logic [63:0] idle_sum;
	logic [63:0] enter_stamp;
	logic [63:0] prev_report_stamp;
	logic [63:0] prev_idle_sum;
	logic        have_report;
	logic [6:0]  share_window[WINDOW_DEPTH];
	int          window_wr;
	int          window_fill;
	int          window_total;

	initial begin
		idle_sum          = '0;
		enter_stamp       = '0;
		prev_report_stamp = '0;
		prev_idle_sum     = '0;
		have_report       = 1'b0;
		window_wr         = 0;
		window_fill       = 0;
		window_total      = 0;
	end

	function automatic logic [6:0] window_mean();
		if (window_fill == 0)
			return '0;
		return 7'(window_total / window_fill);
	endfunction

	// Apply one accepted event to the predictor; report ticks yield a percentage.
	task automatic track_idle_event(input logic [1:0] code, input logic [63:0] stamp,
			output logic has_result, output logic [6:0] percent);
		logic [63:0] elapsed;
		logic [63:0] idle_delta;
		logic [70:0] scaled;
		logic [6:0]  share;
		has_result = 1'b0;
		percent    = '0;
		case (code)
			itm_pkg::EV_ENTER: begin
				enter_stamp = stamp;
			end
			itm_pkg::EV_EXIT: begin
				idle_sum = idle_sum + (stamp - enter_stamp);
			end
			itm_pkg::EV_REPORT: begin
				has_result = 1'b1;
				elapsed    = stamp - prev_report_stamp;
				if (!have_report) begin
					// First tick only opens the measurement period.
					have_report       = 1'b1;
					prev_report_stamp = stamp;
					prev_idle_sum     = idle_sum;
				end else if (elapsed == '0) begin
					percent = window_mean();
				end else begin
					idle_delta = idle_sum - prev_idle_sum;
					if (idle_delta >= elapsed) begin
						share = itm_pkg::PCT_FULL;
					end else begin
						// Keep the product wide so huge periods do not overflow.
						scaled = {7'd0, idle_delta} * 71'd100;
						share  = 7'(scaled / {7'd0, elapsed});
					end
					prev_report_stamp = stamp;
					prev_idle_sum     = idle_sum;
					if (window_fill == WINDOW_DEPTH)
						window_total -= share_window[window_wr];
					else
						window_fill++;
					share_window[window_wr] = share;
					window_total += share;
					window_wr = (window_wr + 1) % WINDOW_DEPTH;
					percent = window_mean();
				end
			end
			default: begin
				// Unused code: drop it, nothing changes.
			end
		endcase
	endtask

	function automatic logic sender_idles();
		if (idle_mode == IDLE_SENDER)
			return $urandom_range(0, 99) < 75;
		if (idle_mode == IDLE_BOTH)
			return $urandom_range(0, 99) < 6;
		return 1'b0;
	endfunction

	function automatic logic receiver_stalls();
		if (idle_mode == IDLE_RECEIVER)
			return $urandom_range(0, 99) < 75;
		if (idle_mode == IDLE_BOTH)
			return $urandom_range(0, 99) < 6;
		return 1'b0;
	endfunction

	// Driver: predict each accepted transaction, then load the next pending one.
	// Valid holds with its payload until the block takes it.
	always @(posedge clk) begin
		logic       has_result;
		logic [6:0] percent;
		idle_event_t next_event;
		if (arst_n) begin
			if (event_valid && event_ready) begin
				track_idle_event(event_code, timestamp, has_result, percent);
				if (has_result)
					expected_percents.push_back(percent);
				events_accepted <= events_accepted + 1;
			end
			if (!event_valid || event_ready) begin
				if (pending_events.size() != 0 && !sender_idles()) begin
					next_event  = pending_events.pop_front();
					event_valid <= 1'b1;
					event_code  <= next_event.code;
					timestamp   <= next_event.stamp;
				end else begin
					event_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here so the block backs up and drops ready.
	always @(posedge clk) begin
		if (!hold_done && events_accepted >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	task automatic note_failure(input string what, input logic [6:0] want,
			input logic [6:0] got);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s idle_percent expected %0d got %0d", $realtime, what, want, got);
	endtask

	// Monitor: compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		logic [6:0] want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_percents.size() == 0) begin
					note_failure("unexpected result,", 'x, idle_percent);
				end else begin
					want = expected_percents.pop_front();
					if (idle_percent !== want)
						note_failure("mismatch,", want, idle_percent);
				end
			end
			result_ready <= (hold_left == 0) && !receiver_stalls();
		end
	end

	function automatic logic [63:0] random_step();
		case ($urandom_range(0, 9))
			0:       return '0;
			1, 2, 3,
			4, 5:    return 64'($urandom_range(1, 1000));
			6, 7:    return 64'($urandom);
			8:       return {$urandom, $urandom} >> $urandom_range(0, 40);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic queue_event(input logic [1:0] code, input logic [63:0] stamp);
		idle_event_t item;
		item.code  = code;
		item.stamp = stamp;
		pending_events.push_back(item);
	endtask

	// One measurement period: a few idle runs, then a report tick.
	// Sprinkle noise, timer jumps and repeated ticks around it.
	task automatic queue_period();
		int idle_runs;
		idle_runs = $urandom_range(0, 3);
		if ($urandom_range(0, 7) == 0)
			time_cursor = {$urandom, $urandom};
		repeat (idle_runs) begin
			if ($urandom_range(0, 3) != 0)
				time_cursor += random_step();
			queue_event(itm_pkg::EV_ENTER, time_cursor);
			time_cursor += random_step();
			queue_event(itm_pkg::EV_EXIT, time_cursor);
		end
		if ($urandom_range(0, 5) == 0)
			queue_event(2'($urandom_range(0, 3)), {$urandom, $urandom});
		if ($urandom_range(0, 2) != 0)
			time_cursor += random_step();
		queue_event(itm_pkg::EV_REPORT, time_cursor);
		if ($urandom_range(0, 9) == 0)
			queue_event(itm_pkg::EV_REPORT, time_cursor);
	endtask

	task automatic queue_random(input int count);
		int target;
		target = pending_events.size() + count;
		while (pending_events.size() < target)
			queue_period();
	endtask

	task automatic queue_directed();
		queue_event(EV_UNUSED, '1);                             // unused code is ignored
		queue_event(itm_pkg::EV_EXIT, 64'd50);                  // exit without enter
		queue_event(itm_pkg::EV_REPORT, 64'd100);               // first tick answers zero
		queue_event(itm_pkg::EV_REPORT, 64'd100);               // zero elapsed, empty window
		queue_event(itm_pkg::EV_ENTER, 64'd100);
		queue_event(itm_pkg::EV_EXIT, 64'd150);
		queue_event(itm_pkg::EV_REPORT, 64'd200);               // half idle
		queue_event(itm_pkg::EV_REPORT, 64'd200);               // zero elapsed, window mean
		queue_event(itm_pkg::EV_ENTER, 64'd200);
		queue_event(itm_pkg::EV_EXIT, 64'd300);
		queue_event(itm_pkg::EV_REPORT, 64'd300);               // idle equals elapsed
		queue_event(itm_pkg::EV_EXIT, 64'd1300);
		queue_event(itm_pkg::EV_REPORT, 64'd400);               // idle beyond elapsed
		queue_event(itm_pkg::EV_ENTER, 64'hFFFF_FFFF_FFFF_FFF0);
		queue_event(itm_pkg::EV_EXIT, 64'h10);                  // idle run across timer wrap
		queue_event(itm_pkg::EV_REPORT, 64'h0);                 // elapsed wraps too
		queue_event(itm_pkg::EV_REPORT, '1);                    // largest elapsed
		queue_event(itm_pkg::EV_ENTER, '0);
		queue_event(itm_pkg::EV_EXIT, 64'h7FFF_FFFF_FFFF_FFFE);
		queue_event(itm_pkg::EV_REPORT, 64'h7FFF_FFFF_FFFF_FFFE); // product needs 70 bits
		queue_event(itm_pkg::EV_REPORT, 64'h8000_0000_0000_0000);
	endtask

	// Wait until everything queued has gone through and come back.
	task automatic drain();
		while (pending_events.size() != 0 || event_valid || expected_percents.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// No idling: directed items, then random ones; the hold-off lands here.
		queue_directed();
		queue_random(150);
		drain();
		@(negedge clk);
		idle_mode = IDLE_SENDER;
		queue_random(130);
		drain();
		@(negedge clk);
		idle_mode = IDLE_RECEIVER;
		queue_random(130);
		drain();
		@(negedge clk);
		idle_mode = IDLE_BOTH;
		queue_random(130);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_percents.size() != 0)
			error_count++;
		if (error_count == 0)
			$display("[idle_time_utilization_monitor_core] OK");
		else
			$display("[idle_time_utilization_monitor_core] ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("[idle_time_utilization_monitor_core] ERROR");
		$finish;
	end

endmodule

FILE: files.f
src/itm_pkg.sv
src/itm_ctrl.sv
src/itm_dp.sv
src/idle_time_utilization_monitor_core.sv
tb/tb_top.sv
